// ----- hdl/scm_pkg.sv -----
// ----------------------------------------------------------------------------
// scm_pkg - shared types and constants of the scrolling clock marquee
// Frame geometry, digit font, register map and a helper function.
// ----------------------------------------------------------------------------
package scm_pkg;

	localparam int FRAME_ROWS  = 7;
	localparam int FRAME_COLS  = 8;
	localparam int DIGIT_COUNT = 4;
	localparam int DIGIT_W     = 4;
	localparam int FONT_WIDTH  = 5;
	localparam int GLYPHS      = 10;
	localparam int POS_W       = 8;
	localparam int COL_W       = 4;

	localparam int APB_ADDR_W  = 3;
	localparam int APB_DATA_W  = 32;

	localparam logic [0:0] REG_PASS_END = 1'b0;

	localparam logic [POS_W-1:0] PASS_END_RST = 8'd12;

	localparam logic [COL_W-1:0] COLON_SLOT = 4'd7;
	localparam logic [COL_W-1:0] GAP_END    = 4'd8;
	localparam logic [COL_W-1:0] FONT_LAST  = COL_W'(FONT_WIDTH);
	localparam logic [POS_W-1:0] HOURS_UNIT = 8'd1;
	localparam logic [POS_W-1:0] DIGIT_END  = POS_W'(DIGIT_COUNT);

	typedef logic [FRAME_ROWS-1:0] column_t;
	typedef logic [FRAME_COLS-1:0] row_t;
	typedef logic [DIGIT_W-1:0]    digit_t;
	typedef digit_t [DIGIT_COUNT-1:0] digits_t;

	localparam column_t COLON_COL = 7'h24;

	localparam column_t FONT [GLYPHS][FONT_WIDTH] = '{
		'{7'h3E, 7'h51, 7'h49, 7'h45, 7'h3E},
		'{7'h00, 7'h42, 7'h7F, 7'h40, 7'h00},
		'{7'h62, 7'h51, 7'h49, 7'h49, 7'h46},
		'{7'h22, 7'h49, 7'h49, 7'h49, 7'h36},
		'{7'h18, 7'h14, 7'h12, 7'h7F, 7'h10},
		'{7'h2F, 7'h49, 7'h49, 7'h49, 7'h31},
		'{7'h3C, 7'h4A, 7'h49, 7'h49, 7'h30},
		'{7'h01, 7'h71, 7'h09, 7'h05, 7'h03},
		'{7'h36, 7'h49, 7'h49, 7'h49, 7'h36},
		'{7'h06, 7'h49, 7'h49, 7'h29, 7'h1E}
	};

	// codes above nine and columns past the glyph are blank
	function automatic column_t glyph_col(digit_t d, logic [2:0] c);
		column_t res;
		res = '0;
		if (d < DIGIT_W'(GLYPHS) && c < 3'(FONT_WIDTH)) begin
			res = FONT[d][c];
		end
		return res;
	endfunction

endpackage

// ----- hdl/scm_if.sv -----
// ----------------------------------------------------------------------------
// scm_if - item channels of the scrolling clock marquee
// Tick channel carries the time digits; frame channel carries the rows.
// ----------------------------------------------------------------------------
interface scm_tick_if;
	import scm_pkg::*;

	logic   valid;
	logic   ready;
	digit_t hours_tens;
	digit_t hours_units;
	digit_t minutes_tens;
	digit_t minutes_units;

	modport source (output valid, hours_tens, hours_units, minutes_tens, minutes_units,
		input ready);
	modport sink (input valid, hours_tens, hours_units, minutes_tens, minutes_units,
		output ready);
endinterface

interface scm_frame_if;
	import scm_pkg::*;

	logic valid;
	logic ready;
	row_t row_0;
	row_t row_1;
	row_t row_2;
	row_t row_3;
	row_t row_4;
	row_t row_5;
	row_t row_6;
	logic pass_wrapped;

	modport source (output valid, row_0, row_1, row_2, row_3, row_4, row_5, row_6,
		pass_wrapped, input ready);
	modport sink (input valid, row_0, row_1, row_2, row_3, row_4, row_5, row_6,
		pass_wrapped, output ready);
endinterface

// ----- hdl/scm_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// scm_cfg_regs - configuration register file
// APB-style access to the pass end count; no wait states.
// ----------------------------------------------------------------------------
module scm_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [scm_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [scm_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [scm_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready,
	output logic [scm_pkg::POS_W-1:0]       pass_end
);
	import scm_pkg::*;

	logic [POS_W-1:0] pass_end_q;
	logic             sel_pass_end;

	assign pready       = 1'b1;
	assign sel_pass_end = (paddr[APB_ADDR_W-1:2] == REG_PASS_END);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_end_q <= PASS_END_RST;
		end else if (psel && penable && pwrite && pready && sel_pass_end) begin
			pass_end_q <= pwdata[POS_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_pass_end) begin
			prdata = {{(APB_DATA_W-POS_W){1'b0}}, pass_end_q};
		end
	end

	assign pass_end = pass_end_q;
endmodule

// ----- hdl/scm_engine.sv -----
// ----------------------------------------------------------------------------
// scm_engine - column sequencer and frame buffer
// Picks the next column of hh:mm, shifts it into the frame, tracks the pass.
// ----------------------------------------------------------------------------
module scm_engine (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step,
	input  scm_pkg::digits_t         digits,
	input  logic [scm_pkg::POS_W-1:0] pass_end,
	output scm_pkg::row_t            frame [scm_pkg::FRAME_ROWS],
	output logic                     wrapped
);
	import scm_pkg::*;

	row_t             frame_q [FRAME_ROWS];
	logic             wrapped_q;
	logic [POS_W-1:0] digit_q;
	logic [COL_W-1:0] col_q;
	digits_t          latched_q;
	logic             loaded_q;

	digits_t          eff_digits;
	digits_t          latched_d;
	digit_t           cur_digit;
	column_t          column;
	logic [POS_W-1:0] digit_d;
	logic [COL_W-1:0] col_d;
	logic [COL_W-1:0] col_inc;
	logic [POS_W:0]   pos_next;
	logic             wrap_d;

	assign eff_digits = loaded_q ? latched_q : digits;
	assign cur_digit  = eff_digits[digit_q[1:0]];
	assign col_inc    = col_q + 1'b1;
	assign pos_next   = {1'b0, digit_q} + 1'b1;

	always_comb begin
		column    = '0;
		digit_d   = digit_q;
		col_d     = col_q;
		wrap_d    = 1'b0;
		latched_d = eff_digits;
		if (digit_q < DIGIT_END) begin
			if (col_q < FONT_LAST) begin
				column = glyph_col(cur_digit, col_q[2:0]);
				col_d  = col_inc;
			end else if (digit_q == HOURS_UNIT) begin
				col_d = col_inc;
				if (col_inc == COLON_SLOT) begin
					column = COLON_COL;
				end
				if (col_inc >= GAP_END) begin
					col_d   = '0;
					digit_d = digit_q + 1'b1;
				end
			end else begin
				col_d   = '0;
				digit_d = digit_q + 1'b1;
			end
		end else if (pos_next > {1'b0, pass_end}) begin
			digit_d   = '0;
			wrap_d    = 1'b1;
			latched_d = digits;
		end else begin
			digit_d = pos_next[POS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < FRAME_ROWS; r++) begin
				frame_q[r] <= '0;
			end
			wrapped_q <= 1'b0;
			digit_q   <= '0;
			col_q     <= '0;
			latched_q <= '0;
			loaded_q  <= 1'b0;
		end else if (step) begin
			for (int r = 0; r < FRAME_ROWS; r++) begin
				frame_q[r] <= {frame_q[r][FRAME_COLS-2:0], column[r]};
			end
			wrapped_q <= wrap_d;
			digit_q   <= digit_d;
			col_q     <= col_d;
			latched_q <= latched_d;
			loaded_q  <= 1'b1;
		end
	end

	assign frame   = frame_q;
	assign wrapped = wrapped_q;
endmodule

// ----- hdl/scrolling_clock_marquee.sv -----
// ----------------------------------------------------------------------------
// scrolling_clock_marquee - 7x8 LED frame scroller showing hh:mm
// Input register, column sequencer with frame buffer, output handshake.
// ----------------------------------------------------------------------------
// channel  dir  handshake        payload
// tick     in   valid / ready    hours_tens, hours_units, minutes_tens, minutes_units
// frame    out  valid / ready    row_0 .. row_6, pass_wrapped
// apb      in   psel / penable   pass_end at byte address 0
//
// One item per cycle sustained while frame.ready holds; an item passes the input register, then the frame register.
// The frame register doubles as the output register; it steps only when empty or taken.
// A stalled frame holds one item in the input register, then tick.ready drops.
// Reset clears the frame, sequencer and latched digits; pass_end resets to 12.
// ----------------------------------------------------------------------------
module scrolling_clock_marquee (
	input  logic                            clk,
	input  logic                            arst_n,
	scm_tick_if.sink                        tick,
	scm_frame_if.source                     frame,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [scm_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [scm_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [scm_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready
);
	import scm_pkg::*;

	logic             valid_s1;
	digits_t          digits_s1;
	logic             out_valid_q;
	logic             step;
	logic             out_free;
	logic [POS_W-1:0] pass_end;
	row_t             rows [FRAME_ROWS];
	logic             wrapped;

	assign out_free   = !out_valid_q || frame.ready;
	assign step       = valid_s1 && out_free;
	assign tick.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (tick.ready) begin
				valid_s1 <= tick.valid;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick.ready && tick.valid) begin
			digits_s1 <= {tick.minutes_units, tick.minutes_tens,
				tick.hours_units, tick.hours_tens};
		end
	end

	scm_cfg_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.pass_end (pass_end)
	);

	scm_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.digits   (digits_s1),
		.pass_end (pass_end),
		.frame    (rows),
		.wrapped  (wrapped)
	);

	assign frame.valid        = out_valid_q;
	assign frame.row_0        = rows[0];
	assign frame.row_1        = rows[1];
	assign frame.row_2        = rows[2];
	assign frame.row_3        = rows[3];
	assign frame.row_4        = rows[4];
	assign frame.row_5        = rows[5];
	assign frame.row_6        = rows[6];
	assign frame.pass_wrapped = wrapped;
endmodule
